>>> rtl/bft_pkg.sv
`timescale 1ns / 1ps
package bft_pkg;

  localparam int QUEUE_LOG   = 5;
  localparam int QUEUE_DEPTH = 1 << QUEUE_LOG;

  localparam logic [7:0] CFG_STANCE = 8'd0;
  localparam logic [7:0] CFG_SPEED  = 8'd1;

  localparam logic [16:0] ONE16  = 17'h10000;
  localparam logic [16:0] HALF16 = 17'h08000;

  typedef struct packed {
    logic [16:0] bt;
    logic [15:0] bu;
  } bft_cfg_t;

  typedef struct packed {
    logic [16:0]        u;
    logic signed [15:0] stride;
    logic [14:0]        lift;
  } bft_item_t;

endpackage

>>> rtl/bft_fifo.sv
`timescale 1ns / 1ps
module bft_fifo #(
  parameter int WIDTH     = 48,
  parameter int DEPTH_LOG = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     head,
  output logic                 nonempty,
  output logic [DEPTH_LOG:0]   level
);

  logic [WIDTH-1:0]     mem [1 << DEPTH_LOG];
  logic [DEPTH_LOG-1:0] wr_ptr;
  logic [DEPTH_LOG-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  assign head     = mem[rd_ptr];
  assign nonempty = (level != '0);

endmodule

>>> rtl/bft_front.sv
`timescale 1ns / 1ps
module bft_front import bft_pkg::*; #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bft_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_phase,
  input  logic signed [15:0] in_stride,
  input  logic [14:0]        in_lift,
  input  logic               q_pop,
  output logic               q_push,
  output bft_item_t          q_item
);

  localparam logic [1:0] SEG_RISE   = 2'd0;
  localparam logic [1:0] SEG_MID_LO = 2'd1;
  localparam logic [1:0] SEG_MID_HI = 2'd2;
  localparam logic [1:0] SEG_FALL   = 2'd3;
  localparam int         DIV_STEPS  = 17;

  typedef struct packed {
    logic [16:0]        rem;
    logic [16:0]        nlo;
    logic [16:0]        q;
    logic [16:0]        d;
    logic [1:0]         kind;
    logic signed [15:0] stride;
    logic [14:0]        lift;
  } div_t;

  logic [QUEUE_LOG:0] occ;
  logic               accept;
  logic [15:0]        x_in;

  logic               a_valid;
  logic [15:0]        a_x;
  logic signed [15:0] a_stride;
  logic [14:0]        a_lift;

  logic [16:0] twox;
  logic [16:0] lo_edge;
  logic [17:0] hi_edge;
  logic [16:0] span_u;
  logic [16:0] mag;
  logic [16:0] y;
  logic [33:0] num;
  logic [16:0] den;
  logic [1:0]  kind;
  div_t        dv_init;

  logic        dv_v [1:DIV_STEPS];
  div_t        dv_r [1:DIV_STEPS];
  div_t        dv_next [1:DIV_STEPS];

  logic [17:0] u_raw;
  logic [16:0] u_fin;
  logic        p_valid;
  bft_item_t   p_item;

  generate
    if (PHASE_FRAC_BITS >= 16) begin : g_wide
      assign x_in = in_phase[PHASE_FRAC_BITS-1 -: 16];
    end else begin : g_narrow
      assign x_in = {in_phase[PHASE_FRAC_BITS-1:0], {(16-PHASE_FRAC_BITS){1'b0}}};
    end
  endgenerate

  assign in_ready = ~occ[QUEUE_LOG];
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      unique case ({accept, q_pop})
        2'b10:   occ <= occ + 1'b1;
        2'b01:   occ <= occ - 1'b1;
        default: occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_x      <= x_in;
    a_stride <= in_stride;
    a_lift   <= in_lift;
  end

  always_comb begin
    twox    = {a_x, 1'b0};
    lo_edge = ONE16 - cfg.bt;
    hi_edge = {1'b0, ONE16} + {1'b0, cfg.bt};
    span_u  = ONE16 - {1'b0, cfg.bu};
    y       = ONE16 - {1'b0, a_x};
    mag     = (twox < ONE16) ? (ONE16 - twox) : (twox - ONE16);
    num     = '0;
    den     = lo_edge;
    kind    = SEG_RISE;
    priority if (twox < lo_edge) begin
      num = 34'({1'b0, a_x}) * 34'(span_u);
    end else if ({1'b0, twox} <= hi_edge) begin
      kind = (twox < ONE16) ? SEG_MID_LO : SEG_MID_HI;
      num  = 34'(mag) * 34'(cfg.bu);
      den  = {cfg.bt[15:0], 1'b0};
    end else begin
      kind = SEG_FALL;
      num  = 34'(y) * 34'(span_u);
    end
    num = num + 34'(den[16:1]);
    dv_init.rem    = num[33:17];
    dv_init.nlo    = num[16:0];
    dv_init.q      = '0;
    dv_init.d      = den;
    dv_init.kind   = kind;
    dv_init.stride = a_stride;
    dv_init.lift   = a_lift;
  end

  // one quotient bit per stage
  always_comb begin
    div_t        src;
    logic [17:0] r2;
    logic [17:0] diff;
    logic        ge;
    for (int i = 1; i <= DIV_STEPS; i++) begin
      src  = (i == 1) ? dv_init : dv_r[i-1];
      r2   = {src.rem, src.nlo[16]};
      diff = r2 - {1'b0, src.d};
      ge   = (r2 >= {1'b0, src.d});
      dv_next[i]     = src;
      dv_next[i].rem = ge ? diff[16:0] : r2[16:0];
      dv_next[i].nlo = {src.nlo[15:0], 1'b0};
      dv_next[i].q   = {src.q[15:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= DIV_STEPS; i++) begin
      dv_r[i] <= dv_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      p_valid <= 1'b0;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        dv_v[i] <= 1'b0;
      end
    end else begin
      a_valid <= accept;
      dv_v[1] <= a_valid;
      for (int i = 2; i <= DIV_STEPS; i++) begin
        dv_v[i] <= dv_v[i-1];
      end
      p_valid <= dv_v[DIV_STEPS];
    end
  end

  always_comb begin
    unique case (dv_r[DIV_STEPS].kind)
      SEG_RISE:   u_raw = {1'b0, dv_r[DIV_STEPS].q};
      SEG_MID_LO: u_raw = (dv_r[DIV_STEPS].q > HALF16) ? 18'd0
                          : {1'b0, HALF16 - dv_r[DIV_STEPS].q};
      SEG_MID_HI: u_raw = {1'b0, HALF16} + {1'b0, dv_r[DIV_STEPS].q};
      SEG_FALL:   u_raw = (dv_r[DIV_STEPS].q > ONE16) ? 18'd0
                          : {1'b0, ONE16 - dv_r[DIV_STEPS].q};
      default:    u_raw = '0;
    endcase
    u_fin = (u_raw > {1'b0, ONE16}) ? ONE16 : u_raw[16:0];
  end

  always_ff @(posedge clk) begin
    p_item.u      <= u_fin;
    p_item.stride <= dv_r[DIV_STEPS].stride;
    p_item.lift   <= dv_r[DIV_STEPS].lift;
  end

  assign q_push = p_valid;
  assign q_item = p_item;

endmodule

>>> rtl/bft_back.sv
`timescale 1ns / 1ps
module bft_back import bft_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  bft_item_t          q_item,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_push,
  output logic signed [15:0] out_x,
  output logic [14:0]        out_z
);

  localparam int          POW_N = 6;
  localparam logic [21:0] MX    = 22'd2684355;
  localparam logic [22:0] MZ    = 23'd6710887;

  typedef struct packed {
    logic [16:0]             u;
    logic [16:0]             v;
    logic [POW_N:1][30:0]    pu;
    logic [POW_N:1][30:0]    pv;
    logic signed [15:0]      stride;
    logic [14:0]             lift;
  } pw_t;

  logic [QUEUE_LOG:0] occ;
  pw_t                pw_first;
  pw_t                pw_r [1:POW_N];
  pw_t                pw_next [2:POW_N];
  logic               pw_v [1:POW_N];
  logic [16:0]        v_in;

  logic               m_v;
  logic [30:0]        m_r [0:POW_N];
  logic signed [15:0] m_stride;
  logic [14:0]        m_lift;
  logic [60:0]        mprod [1:POW_N-1];

  logic signed [39:0] sx;
  logic [39:0]        sx_abs;
  logic [39:0]        sz;
  logic               s_v;
  logic               s_xneg;
  logic [36:0]        s_sxmag;
  logic [36:0]        s_sz;
  logic [15:0]        s_dmag;
  logic [14:0]        s_lift;

  logic               c_v;
  logic               c_xneg;
  logic [34:0]        c_px_lo;
  logic [33:0]        c_px_hi;
  logic [33:0]        c_pz_lo;
  logic [32:0]        c_pz_hi;
  logic [14:0]        c_lift;

  logic [55:0]        ax;
  logic [55:0]        ax7;
  logic [55:0]        az;
  logic               t_v;
  logic               t_xneg;
  logic [24:0]        t_x;
  logic [21:0]        t_z;
  logic [14:0]        t_lift;

  logic [42:0]        prod_x;
  logic [44:0]        prod_z;
  logic               r_v;
  logic               r_xneg;
  logic               r_sat;
  logic [15:0]        r_qx;
  logic [19:0]        r_qz;
  logic [14:0]        r_lift;

  logic [16:0]        mag;
  logic               o_v;
  logic signed [15:0] o_x;
  logic [14:0]        o_z;

  assign q_pop = q_valid & ~occ[QUEUE_LOG];
  assign v_in  = ONE16 - q_item.u;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      unique case ({q_pop, out_pop})
        2'b10:   occ <= occ + 1'b1;
        2'b01:   occ <= occ - 1'b1;
        default: occ <= occ;
      endcase
    end
  end

  always_comb begin
    pw_first        = '0;
    pw_first.u      = q_item.u;
    pw_first.v      = v_in;
    pw_first.pu[1]  = {q_item.u, 14'b0};
    pw_first.pv[1]  = {v_in, 14'b0};
    pw_first.stride = q_item.stride;
    pw_first.lift   = q_item.lift;
  end

  // one power of u and of 1-u per stage
  always_comb begin
    logic [47:0] pu_prod;
    logic [47:0] pv_prod;
    for (int k = 2; k <= POW_N; k++) begin
      pu_prod = 48'(pw_r[k-1].pu[k-1]) * 48'(pw_r[k-1].u) + 48'd32768;
      pv_prod = 48'(pw_r[k-1].pv[k-1]) * 48'(pw_r[k-1].v) + 48'd32768;
      pw_next[k]       = pw_r[k-1];
      pw_next[k].pu[k] = pu_prod[46:16];
      pw_next[k].pv[k] = pv_prod[46:16];
    end
  end

  always_ff @(posedge clk) begin
    pw_r[1] <= pw_first;
    for (int k = 2; k <= POW_N; k++) begin
      pw_r[k] <= pw_next[k];
    end
  end

  always_comb begin
    for (int k = 1; k < POW_N; k++) begin
      mprod[k] = 61'(62'(pw_r[POW_N].pu[k]) * 62'(pw_r[POW_N].pv[POW_N-k]) + 62'(1 << 29));
    end
  end

  always_ff @(posedge clk) begin
    m_r[0] <= pw_r[POW_N].pv[POW_N];
    m_r[POW_N] <= pw_r[POW_N].pu[POW_N];
    for (int k = 1; k < POW_N; k++) begin
      m_r[k] <= mprod[k][60:30];
    end
    m_stride <= pw_r[POW_N].stride;
    m_lift   <= pw_r[POW_N].lift;
  end

  always_comb begin
    sx = 40'sd24 * $signed(40'(m_r[1])) + 40'sd75 * $signed(40'(m_r[2]))
       - 40'sd75 * $signed(40'(m_r[4])) - 40'sd24 * $signed(40'(m_r[5]));
    sx_abs = (sx < 0) ? 40'(-sx) : 40'(sx);
    sz = 40'd5 * 40'(m_r[0]) + 40'd18 * 40'(m_r[1]) + 40'd15 * 40'(m_r[2])
       + 40'd15 * 40'(m_r[4]) + 40'd18 * 40'(m_r[5]) + 40'd5 * 40'(m_r[6]);
  end

  always_ff @(posedge clk) begin
    s_xneg  <= (m_stride < 0) == (sx < 0);
    s_sxmag <= sx_abs[36:0];
    s_sz    <= sz[36:0];
    s_dmag  <= (m_stride < 0) ? 16'(-m_stride) : 16'(m_stride);
    s_lift  <= m_lift;
  end

  always_ff @(posedge clk) begin
    c_xneg  <= s_xneg;
    c_px_lo <= 35'(s_dmag) * 35'(s_sxmag[18:0]);
    c_px_hi <= 34'(s_dmag) * 34'(s_sxmag[36:19]);
    c_pz_lo <= 34'(s_lift) * 34'(s_sz[18:0]);
    c_pz_hi <= 33'(s_lift) * 33'(s_sz[36:19]);
    c_lift  <= s_lift;
  end

  always_comb begin
    ax  = 56'({c_px_hi, 19'b0}) + 56'(c_px_lo);
    ax7 = (ax << 3) - ax + (56'd25 << 30);
    az  = 56'({c_pz_hi, 19'b0}) + 56'(c_pz_lo) + (56'd5 << 29);
  end

  always_ff @(posedge clk) begin
    t_xneg <= c_xneg;
    t_x    <= ax7[54:30];
    t_z    <= az[51:30];
    t_lift <= c_lift;
  end

  always_comb begin
    prod_x = 43'(t_x[20:0]) * 43'(MX);
    prod_z = 45'(t_z) * 45'(MZ);
  end

  always_ff @(posedge clk) begin
    r_xneg <= t_xneg;
    r_sat  <= (t_x >= 25'd1638400);
    r_qx   <= prod_x[42:27];
    r_qz   <= prod_z[44:25];
    r_lift <= t_lift;
  end

  assign mag = r_sat ? 17'd32768 : {1'b0, r_qx};

  always_ff @(posedge clk) begin
    if (r_xneg) begin
      o_x <= 16'(-mag);
    end else begin
      o_x <= (mag > 17'd32767) ? 16'sd32767 : $signed(mag[15:0]);
    end
    o_z <= (r_qz > 20'(r_lift)) ? r_lift : r_qz[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= POW_N; k++) begin
        pw_v[k] <= 1'b0;
      end
      m_v <= 1'b0;
      s_v <= 1'b0;
      c_v <= 1'b0;
      t_v <= 1'b0;
      r_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      pw_v[1] <= q_pop;
      for (int k = 2; k <= POW_N; k++) begin
        pw_v[k] <= pw_v[k-1];
      end
      m_v <= pw_v[POW_N];
      s_v <= m_v;
      c_v <= s_v;
      t_v <= c_v;
      r_v <= t_v;
      o_v <= r_v;
    end
  end

  assign out_push = o_v;
  assign out_x    = o_x;
  assign out_z    = o_z;

endmodule

>>> rtl/bezier_foot_trajectory_core.sv
`timescale 1ns / 1ps
// Sixth-order Bezier foot trajectory: each input word (phase, stride, lift) gives one
// output word (foot_x, foot_z), in order. One word is taken every cycle while the
// front end has queue room (s_tready high). The phase warp in the front end uses a
// 17-stage pipelined divider, and the back end has a 12-stage power and blend pipeline.
// Each side has a 32-word queue, so either side may stall without stopping the other.
// Configuration (stance_fraction at index 0, speed_ratio at index 1) is to be written
// only while no word is in flight; the block does not enforce this. Other indexes are
// ignored. No clearing pass after reset.
module bezier_foot_trajectory_core import bft_pkg::*; #(
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // phase[31:0], stride[47:32], lift[62:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // foot_x[15:0], foot_z[30:16]
);

  logic [15:0]        stance;
  logic [15:0]        speed;
  bft_cfg_t           cfg;

  logic               q1_push;
  logic               q1_pop;
  logic               q1_nonempty;
  bft_item_t          q1_in;
  logic [47:0]        q1_head;
  logic [QUEUE_LOG:0] q1_level;

  logic               q2_push;
  logic               q2_pop;
  logic signed [15:0] res_x;
  logic [14:0]        res_z;
  logic [30:0]        q2_head;
  logic [QUEUE_LOG:0] q2_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stance <= 16'd32768;
      speed  <= 16'd32768;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_STANCE) begin
        stance <= cfg_data;
      end
      if (cfg_index == CFG_SPEED) begin
        speed <= cfg_data;
      end
    end
  end

  // zero stance fraction behaves as one LSB
  assign cfg.bt = (stance == '0) ? 17'd1 : {1'b0, stance};
  assign cfg.bu = speed;

  bft_front #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_phase  (s_tdata[31:0]),
    .in_stride (s_tdata[47:32]),
    .in_lift   (s_tdata[62:48]),
    .q_pop     (q1_pop),
    .q_push    (q1_push),
    .q_item    (q1_in)
  );

  bft_fifo #(
    .WIDTH     (48),
    .DEPTH_LOG (QUEUE_LOG)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q1_push),
    .push_data (q1_in),
    .pop       (q1_pop),
    .head      (q1_head),
    .nonempty  (q1_nonempty),
    .level     (q1_level)
  );

  bft_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q1_nonempty),
    .q_item   (bft_item_t'(q1_head)),
    .q_pop    (q1_pop),
    .out_pop  (q2_pop),
    .out_push (q2_push),
    .out_x    (res_x),
    .out_z    (res_z)
  );

  bft_fifo #(
    .WIDTH     (31),
    .DEPTH_LOG (QUEUE_LOG)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q2_push),
    .push_data ({res_z, res_x}),
    .pop       (q2_pop),
    .head      (q2_head),
    .nonempty  (m_tvalid),
    .level     (q2_level)
  );

  assign q2_pop  = m_tvalid & m_tready;
  assign m_tdata = {1'b0, q2_head};

`ifndef NO_ASSERTIONS
  a_q1_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q1_push |-> (q1_level != (QUEUE_LOG+1)'(QUEUE_DEPTH)))
    else $error("front queue overflow");

  a_q1_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q1_pop |-> (q1_level != '0))
    else $error("front queue underflow");

  a_q2_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q2_push |-> (q2_level != (QUEUE_LOG+1)'(QUEUE_DEPTH)))
    else $error("output queue overflow");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output word present after reset");
`endif

endmodule

>>> bench/tb_bezier_foot_trajectory_core.sv
`timescale 1ns / 1ps
module tb_bezier_foot_trajectory_core;
  import bft_pkg::*;

  typedef struct packed {
    logic signed [15:0] foot_x;
    logic [14:0]        foot_z;
  } foot_pos_t;

  class foot_scoreboard;
    logic [15:0] stance;
    logic [15:0] speed;
    foot_pos_t   pending[$];
    int          errors;

    function new();
      stance = 16'd32768;
      speed  = 16'd32768;
      errors = 0;
    endfunction

    function longint unsigned rdiv(longint unsigned num, longint unsigned den);
      return (num + den / 2) / den;
    endfunction

    function longint unsigned warp_phase(longint unsigned x);
      longint unsigned bt, bu, twox, u, mg, q, s;
      bt = (stance == 0) ? 1 : stance;
      bu = speed;
      twox = 2 * x;
      if (twox < 65536 - bt) begin
        u = rdiv(x * (65536 - bu), 65536 - bt);
      end else if (twox <= 65536 + bt) begin
        if (twox < 65536) begin
          mg = 65536 - twox;
          q = rdiv(bu * mg, 2 * bt);
          u = (q > 32768) ? 0 : 32768 - q;
        end else begin
          mg = twox - 65536;
          q = rdiv(bu * mg, 2 * bt);
          u = 32768 + q;
        end
      end else begin
        s = rdiv((65536 - x) * (65536 - bu), 65536 - bt);
        u = (s > 65536) ? 0 : 65536 - s;
      end
      if (u > 65536) u = 65536;
      return u;
    endfunction

    function void note_input(logic [31:0] phase, logic signed [15:0] stride,
                             logic [14:0] lift);
      longint unsigned u, v, up[7], vp[7], m[7], dmag, sxmag, mg, zr, h;
      longint sx, sz, xr;
      bit dneg, sxneg;
      foot_pos_t r;
      u = warp_phase(phase[15:0]);
      v = 65536 - u;
      up[0] = 64'd1 << 30;
      vp[0] = 64'd1 << 30;
      for (int k = 1; k <= 6; k++) begin
        up[k] = (up[k-1] * u + 32768) >> 16;
        vp[k] = (vp[k-1] * v + 32768) >> 16;
      end
      for (int k = 0; k <= 6; k++) m[k] = (up[k] * vp[6-k] + (64'd1 << 29)) >> 30;
      sx = 24 * longint'(m[1]) + 75 * longint'(m[2]) - 75 * longint'(m[4])
         - 24 * longint'(m[5]);
      sz = 5 * longint'(m[0]) + 18 * longint'(m[1]) + 15 * longint'(m[2])
         + 15 * longint'(m[4]) + 18 * longint'(m[5]) + 5 * longint'(m[6]);
      dneg = stride < 0;
      dmag = dneg ? -longint'(stride) : longint'(stride);
      sxneg = sx < 0;
      sxmag = sxneg ? -sx : sx;
      mg = rdiv(7 * dmag * sxmag, 50 * (64'd1 << 30));
      if (mg > 32768) mg = 32768;
      xr = (dneg == sxneg) ? -longint'(mg) : longint'(mg);
      if (xr > 32767) xr = 32767;
      h = lift;
      zr = rdiv(h * unsigned'(sz), 5 * (64'd1 << 30));
      if (zr > h) zr = h;
      r.foot_x = xr[15:0];
      r.foot_z = zr[14:0];
      pending.push_back(r);
    endfunction

    function void check_output(logic [31:0] word);
      foot_pos_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", word);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (word[15:0] !== e.foot_x) begin
        $error("foot_x expected %0d actual %0d", e.foot_x, $signed(word[15:0]));
        errors++;
      end
      if (word[30:16] !== e.foot_z) begin
        $error("foot_z expected %0d actual %0d", e.foot_z, word[30:16]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;

  foot_scoreboard sb = new();
  bit  quiet = 0;
  bit  long_hold = 0;
  bit  long_hold_done = 0;
  int  hold_cycles = 0;
  int  idle_count = 0;

  bezier_foot_trajectory_core uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold when requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (long_hold && !long_hold_done) begin
      long_hold_done <= 1;
      hold_cycles <= 300;
      m_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      m_tready <= 0;
      hold_cycles <= $urandom_range(0, 13);
    end else begin
      m_tready <= 1;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_STANCE) sb.stance = val;
    else if (idx == CFG_SPEED) sb.speed = val;
    cfg_valid <= 0;
  endtask

  task automatic send_word(logic [31:0] phase, logic signed [15:0] stride,
                           logic [14:0] lift);
    int gap;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      s_tvalid <= 0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {1'b0, lift, stride, phase};
    do @(posedge clk); while (!s_tready);
    sb.note_input(phase, stride, lift);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_random(int n);
    logic [31:0] ph;
    for (int i = 0; i < n; i++) begin
      ph = $urandom;
      case ($urandom_range(0, 7))
        0: ph[15:0] = 16'h0000;
        1: ph[15:0] = 16'hFFFF;
        2: ph[15:0] = 16'(16'h8000 + $urandom_range(0, 4) - 2);
        default: ;
      endcase
      send_word(ph, 16'($urandom), 15'($urandom));
    end
  endtask

  initial begin
    logic [15:0] st_vals[6];
    logic [15:0] sp_vals[6];
    st_vals = '{16'd32768, 16'd1, 16'd65535, 16'd0, 16'd12000, 16'd50000};
    sp_vals = '{16'd32768, 16'd0, 16'd65535, 16'd40000, 16'd65535, 16'd3};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_word(32'h0000_0000, 16'sh7FFF, 15'h7FFF);
    send_word(32'hFFFF_FFFF, -16'sh8000, 15'h7FFF);
    send_word(32'h0001_8000, -16'sh8000, 15'h0000);
    send_word(32'h0000_4000, 16'sh7FFF, 15'h7FFF);
    send_word(32'h0000_C000, -16'sh8000, 15'h4000);
    send_word(32'hAAAA_5555, 16'sh0000, 15'h0001);
    send_word(32'h5555_AAAA, 16'sh0001, 15'h2AAA);
    send_word(32'h0000_7FFF, -16'sh0001, 15'h5555);
    send_word(32'h0000_8001, 16'sh5555, 15'h7FFF);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_STANCE, st_vals[p]);
      write_reg(CFG_SPEED, sp_vals[p]);
      write_reg(8'd7, 16'($urandom));
      send_word(32'h0000_0000, 16'sh7FFF, 15'h7FFF);
      send_word(32'h0000_FFFF, -16'sh8000, 15'h7FFF);
      send_word(32'h0000_8000, 16'sh7FFF, 15'h7FFF);
      send_random(230);
      if (p == 2) begin
        long_hold = 1;
        send_random(120);
      end
      drain();
    end

    write_reg(CFG_STANCE, 16'($urandom_range(1, 65535)));
    write_reg(CFG_SPEED, 16'($urandom));
    quiet = 1;
    send_random(100);
    drain();

    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
